### sv/prf_pkg.sv
package prf_pkg;

	// Angle and coefficient formats
	localparam int ANGLE_BITS     = 12;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_BITS      = COEF_FRAC_BITS + 2;  // signed Q1.F with headroom
	localparam int TAB_IDX_BITS   = ANGLE_BITS - 1;      // 0 .. quarter inclusive
	localparam int QUARTER        = 1 << (ANGLE_BITS - 2);
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef logic [ANGLE_BITS-1:0]            angle_t;
	typedef logic signed [COEF_BITS-1:0]      coef_t;
	typedef coef_t [8:0]                      mat_t;   // row-major
	typedef logic [COEF_FRAC_BITS:0]          sin_mag_t;
	typedef sin_mag_t                         sin_tab_t [0:QUARTER];

	localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC_BITS);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NODE      = 2'd0,
		REG_PERIAPSIS = 2'd1,
		REG_TILT      = 2'd2
	} reg_idx_t;

	// per-stage load enables shared by all lanes
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} lane_ctl_t;

	// Q62 fixed-point product, elaboration only
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// unsigned restoring division, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Exactly rounded quarter-wave sine, built by Taylor series in Q62
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] kk;
		logic [63:0] den;
		logic [63:0] lsb;
		lsb = 64'd1 << (61 - COEF_FRAC_BITS);
		for (int k = 0; k <= QUARTER; k++) begin
			kk   = 64'(k);
			x    = (HALF_PI_Q62 >> (ANGLE_BITS - 2)) * kk +
			       (((HALF_PI_Q62 & 64'(QUARTER - 1)) * kk) >> (ANGLE_BITS - 2));
			x2   = mul_q62(x, x);
			term = x;
			sum  = x;
			for (int n = 1; n < 40; n++) begin
				if (term != 64'd0) begin
					den  = 64'((2 * n) * (2 * n + 1));
					term = div_u64(mul_q62(term, x2), den);
					if (n[0])
						sum = sum - term;
					else
						sum = sum + term;
				end
			end
			tab[k] = sin_mag_t'((sum + lsb) >> (62 - COEF_FRAC_BITS));
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

### sv/perifocal_eci_frame_rotation.sv
// Perifocal <-> ECI rotation by the 3-1-3 orbit matrix built from RAAN (node_angle),
// argument of periapsis (periapsis_angle) and inclination (tilt_angle), each a 12-bit
// fraction of a turn. Each transaction carries a vector in tdata and a command in tuser:
// 0 applies the matrix (perifocal to ECI), 1 its transpose (ECI to perifocal). Results
// are rounded half-up from Q1.16 and saturated to VECTOR_BITS; tuser on the result
// flags saturation of any component. Throughput is one transaction per cycle while the
// output drains and no matrix rebuild is running. Three lanes each run one output
// component as a dot product in registered stages (multiply, sum, round/saturate), and
// a merge stage forms the output register that drives m_tvalid. Stages advance
// independently, so input keeps flowing into empty stages while a result waits on
// m_tready. After any write to a valid register index the matrix is rebuilt: six
// quarter-wave table reads, then twelve rounded products on one shared 18x18 multiplier,
// then a commit, during which s_tready is low. The matrix resets to identity.
module perifocal_eci_frame_rotation #(
	parameter int  VECTOR_BITS = 32,
	localparam int DATA_BITS   = ((3 * VECTOR_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [DATA_BITS-1:0]               s_tdata,   // in_x, in_y, in_z
	input  logic [0:0]                         s_tuser,   // command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [DATA_BITS-1:0]               m_tdata,   // out_x, out_y, out_z
	output logic [0:0]                         m_tuser,   // clipped
	input  logic                               cfg_we,
	input  logic [prf_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  prf_pkg::angle_t                    cfg_data
);
	import prf_pkg::*;

	localparam logic [VECTOR_BITS-1:0] VMAX = {1'b0, {(VECTOR_BITS-1){1'b1}}};
	localparam logic [VECTOR_BITS-1:0] VMIN = {1'b1, {(VECTOR_BITS-1){1'b0}}};

	logic                          busy;
	mat_t                          mat;
	logic                          v_s1, v_s2, v_s3;
	logic                          rdy1, rdy2, rdy3, out_rdy;
	lane_ctl_t                     ctl;
	logic signed [VECTOR_BITS-1:0] vec [3];
	logic signed [VECTOR_BITS-1:0] res [3];
	logic                          clip [3];

	// Matrix rebuild sequencer; holds the angle registers and the matrix.
	prf_rebuild u_rebuild (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.busy     (busy),
		.mat      (mat)
	);

	// Unpack the input vector, x in the lowest bits.
	always_comb begin
		for (int j = 0; j < 3; j++)
			vec[j] = s_tdata[j * VECTOR_BITS +: VECTOR_BITS];
	end

	// Each stage loads when it is empty or the next stage takes its content.
	assign rdy3     = !v_s3 || out_rdy;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1 && !busy && !cfg_we;

	assign ctl.en1 = rdy1;
	assign ctl.en2 = rdy2;
	assign ctl.en3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= s_tvalid && s_tready;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	// One lane per output component.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		prf_lane #(
			.VECTOR_BITS (VECTOR_BITS),
			.LANE        (i)
		) u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.transpose (s_tuser[0]),
			.mat       (mat),
			.vec       (vec),
			.res_s3    (res[i]),
			.clip_s3   (clip[i])
		);
	end

	// Output register: packs components and ORs the saturation flags.
	prf_merge #(
		.VECTOR_BITS (VECTOR_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s3     (v_s3),
		.res      (res),
		.clip     (clip),
		.m_tready (m_tready),
		.ready    (out_rdy),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// No transaction may enter while the matrix is being rebuilt.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("input accepted during matrix rebuild");

	// A write to a valid register index starts a rebuild.
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx == REG_NODE || cfg_idx == REG_PERIAPSIS ||
		           cfg_idx == REG_TILT) |=> busy)
		else $error("config write did not start a rebuild");

	// Last lane stage holds its transaction while the output register is full.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_rdy |=> v_s3)
		else $error("lane result dropped under back-pressure");

	// The saturation flag goes with at least one component at a rail.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata[VECTOR_BITS-1:0] == VMAX ||
			 m_tdata[VECTOR_BITS-1:0] == VMIN ||
			 m_tdata[2*VECTOR_BITS-1:VECTOR_BITS] == VMAX ||
			 m_tdata[2*VECTOR_BITS-1:VECTOR_BITS] == VMIN ||
			 m_tdata[3*VECTOR_BITS-1:2*VECTOR_BITS] == VMAX ||
			 m_tdata[3*VECTOR_BITS-1:2*VECTOR_BITS] == VMIN))
		else $error("clipped flag without a saturated component");

endmodule

### sv/prf_rebuild.sv
module prf_rebuild (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [prf_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  prf_pkg::angle_t                     cfg_data,
	output logic                                busy,
	output prf_pkg::mat_t                       mat
);
	import prf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_MULT   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	// trig slots, in the order they are fetched
	localparam int TRIG_SO = 0;
	localparam int TRIG_CO = 1;
	localparam int TRIG_SW = 2;
	localparam int TRIG_CW = 3;
	localparam int TRIG_SI = 4;
	localparam int TRIG_CI = 5;
	localparam logic [3:0] LAST_TRIG = 4'd5;
	localparam logic [3:0] LAST_PROD = 4'd11;
	localparam int PROD_BITS = 2 * COEF_BITS;
	localparam logic signed [PROD_BITS-1:0] PROD_HALF =
		PROD_BITS'(1) << (COEF_FRAC_BITS - 1);

	typedef logic signed [COEF_BITS:0] csum_t;

	state_t                            state_q;
	logic [3:0]                        cnt_q;
	angle_t                            node_q, peri_q, tilt_q;
	logic                              cfg_hit;
	angle_t                            ang;
	logic [1:0]                        quad;
	logic [ANGLE_BITS-3:0]             frac;
	logic [TAB_IDX_BITS-1:0]           rom_idx;
	sin_mag_t                          rom_q;
	logic                              neg_q;
	logic [2:0]                        dst_q;
	logic                              rd_v_q;
	coef_t                             trig_q [0:5];
	coef_t                             prod_q [0:11];
	coef_t                             op_a, op_b;
	logic signed [PROD_BITS-1:0]       mprod;
	coef_t                             rounded;
	mat_t                              mat_next;
	mat_t                              mat_q;

	function automatic coef_t sat_coef(input csum_t v);
		coef_t r;
		if (v[COEF_BITS] != v[COEF_BITS-1])
			r = v[COEF_BITS] ? {1'b1, {(COEF_BITS-1){1'b0}}} : {1'b0, {(COEF_BITS-1){1'b1}}};
		else
			r = v[COEF_BITS-1:0];
		return r;
	endfunction

	assign cfg_hit = cfg_we && (cfg_idx == REG_NODE || cfg_idx == REG_PERIAPSIS ||
	                            cfg_idx == REG_TILT);

	// table address: even steps sine, odd steps cosine (angle plus a quarter)
	always_comb begin
		case (cnt_q[2:1])
			2'd0:    ang = node_q;
			2'd1:    ang = peri_q;
			default: ang = tilt_q;
		endcase
		if (cnt_q[0])
			ang = ang + angle_t'(QUARTER);
		quad = ang[ANGLE_BITS-1:ANGLE_BITS-2];
		frac = ang[ANGLE_BITS-3:0];
		rom_idx = quad[0] ? (TAB_IDX_BITS'(QUARTER) - {1'b0, frac}) : {1'b0, frac};
	end

	// product schedule on the shared multiplier
	always_comb begin
		unique case (cnt_q)
			4'd0:    begin op_a = trig_q[TRIG_CO]; op_b = trig_q[TRIG_CW]; end
			4'd1:    begin op_a = trig_q[TRIG_SO]; op_b = trig_q[TRIG_SW]; end
			4'd2:    begin op_a = trig_q[TRIG_CO]; op_b = trig_q[TRIG_SW]; end
			4'd3:    begin op_a = trig_q[TRIG_SO]; op_b = trig_q[TRIG_CW]; end
			4'd4:    begin op_a = prod_q[1];       op_b = trig_q[TRIG_CI]; end
			4'd5:    begin op_a = prod_q[3];       op_b = trig_q[TRIG_CI]; end
			4'd6:    begin op_a = prod_q[2];       op_b = trig_q[TRIG_CI]; end
			4'd7:    begin op_a = prod_q[0];       op_b = trig_q[TRIG_CI]; end
			4'd8:    begin op_a = trig_q[TRIG_SO]; op_b = trig_q[TRIG_SI]; end
			4'd9:    begin op_a = trig_q[TRIG_CO]; op_b = trig_q[TRIG_SI]; end
			4'd10:   begin op_a = trig_q[TRIG_SW]; op_b = trig_q[TRIG_SI]; end
			4'd11:   begin op_a = trig_q[TRIG_CW]; op_b = trig_q[TRIG_SI]; end
			default: begin op_a = '0;              op_b = '0;              end
		endcase
		mprod   = op_a * op_b + PROD_HALF;
		rounded = mprod[COEF_FRAC_BITS+COEF_BITS-1:COEF_FRAC_BITS];
	end

	// combine rounded products into the 3-1-3 matrix
	always_comb begin
		mat_next[0] = sat_coef(csum_t'(prod_q[0]) - csum_t'(prod_q[4]));
		mat_next[1] = sat_coef(-csum_t'(prod_q[2]) - csum_t'(prod_q[5]));
		mat_next[2] = prod_q[8];
		mat_next[3] = sat_coef(csum_t'(prod_q[3]) + csum_t'(prod_q[6]));
		mat_next[4] = sat_coef(csum_t'(prod_q[7]) - csum_t'(prod_q[1]));
		mat_next[5] = sat_coef(-csum_t'(prod_q[9]));
		mat_next[6] = prod_q[10];
		mat_next[7] = prod_q[11];
		mat_next[8] = trig_q[TRIG_CI];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			node_q  <= '0;
			peri_q  <= '0;
			tilt_q  <= '0;
			rd_v_q  <= 1'b0;
			for (int k = 0; k < 9; k++)
				mat_q[k] <= (k % 4 == 0) ? COEF_ONE : '0;
		end else begin
			rd_v_q <= 1'b0;
			if (cfg_hit) begin
				if (cfg_idx == REG_NODE)
					node_q <= cfg_data;
				else if (cfg_idx == REG_PERIAPSIS)
					peri_q <= cfg_data;
				else
					tilt_q <= cfg_data;
				state_q <= ST_LOAD;
				cnt_q   <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_LOAD: begin
						rd_v_q <= 1'b1;
						if (cnt_q == LAST_TRIG) begin
							state_q <= ST_MULT;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
					ST_MULT: begin
						if (cnt_q == LAST_PROD) begin
							state_q <= ST_COMMIT;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
					ST_COMMIT: begin
						mat_q   <= mat_next;
						state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// table read, sign fix-up and product storage
	always_ff @(posedge clk) begin
		rom_q <= SIN_TAB[rom_idx];
		neg_q <= quad[1];
		dst_q <= cnt_q[2:0];
		if (rd_v_q)
			trig_q[dst_q] <= neg_q ? -coef_t'({1'b0, rom_q}) : coef_t'({1'b0, rom_q});
		if (state_q == ST_MULT)
			prod_q[cnt_q] <= rounded;
	end

	assign busy = (state_q != ST_IDLE);
	assign mat  = mat_q;

endmodule

### sv/prf_lane.sv
module prf_lane #(
	parameter int VECTOR_BITS = 32,
	parameter int LANE        = 0
) (
	input  logic                          clk,
	input  prf_pkg::lane_ctl_t            ctl,
	input  logic                          transpose,
	input  prf_pkg::mat_t                 mat,
	input  logic signed [VECTOR_BITS-1:0] vec [3],
	output logic signed [VECTOR_BITS-1:0] res_s3,
	output logic                          clip_s3
);
	import prf_pkg::*;

	localparam int PROD_BITS = VECTOR_BITS + COEF_BITS;
	localparam int SUM_BITS  = PROD_BITS + 2;
	localparam int RND_BITS  = SUM_BITS - COEF_FRAC_BITS;
	localparam logic signed [SUM_BITS-1:0] SUM_HALF = SUM_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [VECTOR_BITS-1:0] VMAX = {1'b0, {(VECTOR_BITS-1){1'b1}}};
	localparam logic [VECTOR_BITS-1:0] VMIN = {1'b1, {(VECTOR_BITS-1){1'b0}}};

	coef_t                         coef [3];
	logic signed [PROD_BITS-1:0]   prod_s1 [3];
	logic signed [SUM_BITS-1:0]    sum_s2;
	logic signed [RND_BITS-1:0]    rnd;
	logic [RND_BITS-VECTOR_BITS:0] top_bits;

	// row of the matrix, or column for the transpose
	always_comb begin
		for (int j = 0; j < 3; j++)
			coef[j] = transpose ? mat[j * 3 + LANE] : mat[LANE * 3 + j];
	end

	assign rnd      = sum_s2[SUM_BITS-1:COEF_FRAC_BITS];
	assign top_bits = rnd[RND_BITS-1:VECTOR_BITS-1];

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			for (int j = 0; j < 3; j++)
				prod_s1[j] <= coef[j] * vec[j];
		end
		if (ctl.en2)
			sum_s2 <= SUM_BITS'(prod_s1[0]) + SUM_BITS'(prod_s1[1]) +
			          SUM_BITS'(prod_s1[2]) + SUM_HALF;
		if (ctl.en3) begin
			if ((&top_bits) || !(|top_bits)) begin
				res_s3  <= rnd[VECTOR_BITS-1:0];
				clip_s3 <= 1'b0;
			end else begin
				res_s3  <= rnd[RND_BITS-1] ? VMIN : VMAX;
				clip_s3 <= 1'b1;
			end
		end
	end

endmodule

### sv/prf_merge.sv
module prf_merge #(
	parameter int  VECTOR_BITS = 32,
	localparam int DATA_BITS   = ((3 * VECTOR_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          v_s3,
	input  logic signed [VECTOR_BITS-1:0] res [3],
	input  logic                          clip [3],
	input  logic                          m_tready,
	output logic                          ready,
	output logic                          m_tvalid,
	output logic [DATA_BITS-1:0]          m_tdata,   // out_x, out_y, out_z
	output logic [0:0]                    m_tuser    // clipped
);

	assign ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (ready)
			m_tvalid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			m_tdata    <= DATA_BITS'({res[2], res[1], res[0]});
			m_tuser[0] <= clip[0] | clip[1] | clip[2];
		end
	end

endmodule

### tb/perifocal_eci_frame_rotation_chk.sv
module perifocal_eci_frame_rotation_chk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [95:0]               s_tdata,   // in_x, in_y, in_z
	input  logic [0:0]                s_tuser,   // command
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [95:0]               m_tdata,   // out_x, out_y, out_z
	input  logic [0:0]                m_tuser,   // clipped
	input  logic                      cfg_we,
	input  logic [prf_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  prf_pkg::angle_t           cfg_data,
	output int                        mismatches,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     VEC_BITS     = 32;
	localparam int     FRAC         = prf_pkg::COEF_FRAC_BITS;
	localparam int     REPORT_LIMIT = 200;
	localparam longint VEC_HI       = (longint'(1) <<< (VEC_BITS - 1)) - 1;
	localparam longint VEC_LO       = -(longint'(1) <<< (VEC_BITS - 1));
	localparam longint COEF_HI      = (longint'(1) <<< (FRAC + 1)) - 1;
	localparam longint COEF_LO      = -(longint'(1) <<< (FRAC + 1));
	localparam longint HALF_LSB     = longint'(1) <<< (FRAC - 1);

	typedef struct packed {
		logic signed [VEC_BITS-1:0] x;
		logic signed [VEC_BITS-1:0] y;
		logic signed [VEC_BITS-1:0] z;
		logic                       clip;
	} rotated_vec_t;

	prf_pkg::sin_mag_t quarter_wave [0:prf_pkg::QUARTER];
	prf_pkg::angle_t   node_ang;
	prf_pkg::angle_t   peri_ang;
	prf_pkg::angle_t   tilt_ang;
	prf_pkg::coef_t    rot [9];       // row-major
	rotated_vec_t      expected_vecs [$];
	rotated_vec_t      want;
	rotated_vec_t      got;

	// Q62 x Q62 -> Q62, truncated
	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] full;
		full = {64'd0, a} * {64'd0, b};
		return full[125:62];
	endfunction

	// sine of k quarter-steps by odd Taylor series, then rounded to Q1.F
	function automatic prf_pkg::sin_mag_t quarter_wave_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] kk;
		kk   = 64'(k);
		x    = (prf_pkg::HALF_PI_Q62 >> (prf_pkg::ANGLE_BITS - 2)) * kk +
		       (((prf_pkg::HALF_PI_Q62 & 64'(prf_pkg::QUARTER - 1)) * kk)
		        >> (prf_pkg::ANGLE_BITS - 2));
		x2   = q62_product(x, x);
		term = x;
		acc  = x;
		for (int n = 1; n < 40 && term != 64'd0; n++) begin
			term = q62_product(term, x2) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		return prf_pkg::sin_mag_t'((acc + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
	endfunction

	function automatic longint sine_of(input prf_pkg::angle_t a);
		logic [1:0] quad;
		int         r;
		longint     mag;
		quad = a[prf_pkg::ANGLE_BITS-1 -: 2];
		r    = int'(a[prf_pkg::ANGLE_BITS-3:0]);
		mag  = quad[0] ? longint'(quarter_wave[prf_pkg::QUARTER - r])
		               : longint'(quarter_wave[r]);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic longint cosine_of(input prf_pkg::angle_t a);
		return sine_of(prf_pkg::angle_t'(a + prf_pkg::angle_t'(prf_pkg::QUARTER)));
	endfunction

	// Q1.F product, rounded half-up (floor after adding half)
	function automatic longint qmul(input longint a, input longint b);
		return (a * b + HALF_LSB) >>> FRAC;
	endfunction

	function automatic prf_pkg::coef_t clamp_coef(input longint v);
		if (v > COEF_HI) return prf_pkg::coef_t'(COEF_HI);
		if (v < COEF_LO) return prf_pkg::coef_t'(COEF_LO);
		return prf_pkg::coef_t'(v);
	endfunction

	function automatic void load_identity();
		for (int k = 0; k < 9; k++) begin
			rot[k] = (k % 4 == 0) ? prf_pkg::COEF_ONE : prf_pkg::coef_t'(0);
		end
	endfunction

	// 3-1-3 node / periapsis / tilt matrix
	function automatic void rebuild_rotation();
		longint so, co, sw, cw, si, ci;
		so = sine_of(node_ang);
		co = cosine_of(node_ang);
		sw = sine_of(peri_ang);
		cw = cosine_of(peri_ang);
		si = sine_of(tilt_ang);
		ci = cosine_of(tilt_ang);
		rot[0] = clamp_coef(qmul(co, cw) - qmul(qmul(so, sw), ci));
		rot[1] = clamp_coef(-qmul(co, sw) - qmul(qmul(so, cw), ci));
		rot[2] = clamp_coef(qmul(so, si));
		rot[3] = clamp_coef(qmul(so, cw) + qmul(qmul(co, sw), ci));
		rot[4] = clamp_coef(-qmul(so, sw) + qmul(qmul(co, cw), ci));
		rot[5] = clamp_coef(-qmul(co, si));
		rot[6] = clamp_coef(qmul(sw, si));
		rot[7] = clamp_coef(qmul(cw, si));
		rot[8] = clamp_coef(ci);
	endfunction

	// command 1 walks the matrix by columns (transpose)
	function automatic rotated_vec_t rotate_vec(input logic transpose, input logic [95:0] d);
		longint                     v [3];
		longint                     acc;
		longint                     q;
		logic signed [VEC_BITS-1:0] comp [3];
		rotated_vec_t               r;
		v[0]   = longint'($signed(d[31:0]));
		v[1]   = longint'($signed(d[63:32]));
		v[2]   = longint'($signed(d[95:64]));
		r.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				acc += longint'(transpose ? rot[j * 3 + i] : rot[i * 3 + j]) * v[j];
			end
			q = (acc + HALF_LSB) >>> FRAC;
			if (q > VEC_HI) begin
				q      = VEC_HI;
				r.clip = 1'b1;
			end else if (q < VEC_LO) begin
				q      = VEC_LO;
				r.clip = 1'b1;
			end
			comp[i] = q[VEC_BITS-1:0];
		end
		r.x = comp[0];
		r.y = comp[1];
		r.z = comp[2];
		return r;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	initial begin
		for (int k = 0; k <= prf_pkg::QUARTER; k++) quarter_wave[k] = quarter_wave_entry(k);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_ang = '0;
			peri_ang = '0;
			tilt_ang = '0;
			load_identity();
			expected_vecs.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					prf_pkg::REG_NODE: begin
						node_ang = cfg_data;
						rebuild_rotation();
					end
					prf_pkg::REG_PERIAPSIS: begin
						peri_ang = cfg_data;
						rebuild_rotation();
					end
					prf_pkg::REG_TILT: begin
						tilt_ang = cfg_data;
						rebuild_rotation();
					end
					default: ;
				endcase
			end
			// retire before enqueue, so an early output never meets its own input
			if (m_tvalid && m_tready) begin
				got.x    = m_tdata[31:0];
				got.y    = m_tdata[63:32];
				got.z    = m_tdata[95:64];
				got.clip = m_tuser[0];
				if (expected_vecs.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%t: result transaction with nothing outstanding", $time);
				end else begin
					want = expected_vecs.pop_front();
					check_field("out_x", longint'(want.x), longint'(got.x));
					check_field("out_y", longint'(want.y), longint'(got.y));
					check_field("out_z", longint'(want.z), longint'(got.z));
					check_field("clipped", longint'(want.clip), longint'(got.clip));
				end
			end
			if (s_tvalid && s_tready)
				expected_vecs = {expected_vecs, rotate_vec(s_tuser[0], s_tdata)};
			outstanding = expected_vecs.size();
		end
	end

endmodule

### tb/tb_perifocal_eci_frame_rotation.sv
module tb_perifocal_eci_frame_rotation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CLK_HALF       = 6;       // 12 ns period
	localparam int  SETTLE_CYCLES  = 30;      // covers a matrix rebuild plus 4-stage pipe
	localparam int  DRAIN_CYCLES   = 10;
	localparam int  CYCLE_LIMIT    = 200000;
	localparam int  SETTINGS_EACH  = 4;       // angle settings per idling phase
	localparam int  ITEMS_EACH     = 52;      // random transactions per angle setting

	// command codes carried in s_tuser
	localparam logic CMD_TO_ECI       = 1'b0;
	localparam logic CMD_TO_PERIFOCAL = 1'b1;

	// index past the register list: write must be ignored
	localparam logic [prf_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [31:0] VEC_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VEC_MIN = 32'sh8000_0000;

	logic                                   clk      = 1'b0;
	logic                                   arst_n   = 1'b0;
	logic                                   s_tvalid = 1'b0;
	logic                                   s_tready;
	logic [95:0]                            s_tdata  = '0;   // in_x, in_y, in_z
	logic [0:0]                             s_tuser  = '0;   // command
	logic                                   m_tvalid;
	logic                                   m_tready = 1'b0;
	logic [95:0]                            m_tdata;         // out_x, out_y, out_z
	logic [0:0]                             m_tuser;         // clipped
	logic                                   cfg_we   = 1'b0;
	logic [prf_pkg::CFG_IDX_BITS-1:0]       cfg_idx  = '0;
	prf_pkg::angle_t                        cfg_data = '0;

	int mismatches;
	int outstanding;
	int cycle_count   = 0;
	int send_idle_pct = 0;   // chance of a gap before each input transaction
	int recv_idle_pct = 0;   // chance of m_tready low in a given cycle

	perifocal_eci_frame_rotation u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// watches both streams and the config port, predicts and scores
	perifocal_eci_frame_rotation_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #(CLK_HALF) clk = ~clk;

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_perifocal_eci_frame_rotation NOT OK");
			$finish;
		end
	end

	// result backpressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// One input transaction. Valid stays high on return, so back-to-back
	// transactions keep it up without a drop; a gap is a separate negedge.
	task automatic send_vec(input logic cmd, input logic signed [31:0] vx,
	                        input logic signed [31:0] vy, input logic signed [31:0] vz);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vz, vy, vx};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Pause first: the pipe or an earlier rebuild may still be busy even
	// with nothing outstanding.
	task automatic write_angle(input logic [prf_pkg::CFG_IDX_BITS-1:0] idx,
	                           input prf_pkg::angle_t val);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic program_angles(input prf_pkg::angle_t node, input prf_pkg::angle_t peri,
	                              input prf_pkg::angle_t tilt);
		write_angle(prf_pkg::REG_NODE, node);
		write_angle(prf_pkg::REG_PERIAPSIS, peri);
		write_angle(prf_pkg::REG_TILT, tilt);
	endtask

	// extremes and small values weighted up so clipping and rounding get hit
	function automatic logic signed [31:0] pick_component();
		case ($urandom_range(9))
			0:       return VEC_MAX;
			1:       return VEC_MIN;
			2:       return 32'($signed($urandom_range(600)) - 300);
			3:       return VEC_MAX - 32'($urandom_range(65535));
			4:       return VEC_MIN + 32'($urandom_range(65535));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int phase);
		prf_pkg::angle_t node, peri, tilt;
		for (int s = 0; s < SETTINGS_EACH; s++) begin
			node = prf_pkg::angle_t'($urandom_range(4095));
			peri = prf_pkg::angle_t'($urandom_range(4095));
			tilt = prf_pkg::angle_t'($urandom_range(4095));
			// first setting of each phase pins the angle extremes
			if (s == 0) begin
				case (phase)
					0: begin
						node = '1;
						peri = '1;
						tilt = '1;
					end
					1: begin
						node = '0;
						peri = '0;
						tilt = '0;
					end
					default: begin
						node = prf_pkg::angle_t'(2 * prf_pkg::QUARTER);
						peri = prf_pkg::angle_t'(3 * prf_pkg::QUARTER);
						tilt = prf_pkg::angle_t'(prf_pkg::QUARTER);
					end
				endcase
			end
			program_angles(node, peri, tilt);
			for (int n = 0; n < ITEMS_EACH; n++)
				send_vec(1'($urandom_range(1)), pick_component(), pick_component(),
				         pick_component());
			drain();
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 7;
		recv_idle_pct = 85;

		// identity after reset: outputs must equal inputs exactly
		send_vec(CMD_TO_ECI, 32'sd0, 32'sd0, 32'sd0);
		send_vec(CMD_TO_PERIFOCAL, 32'sd0, 32'sd0, 32'sd0);
		send_vec(CMD_TO_ECI, VEC_MAX, VEC_MAX, VEC_MAX);
		send_vec(CMD_TO_PERIFOCAL, VEC_MIN, VEC_MIN, VEC_MIN);
		send_vec(CMD_TO_ECI, VEC_MAX, VEC_MIN, -32'sd1);
		send_vec(CMD_TO_PERIFOCAL, 32'sd1, -32'sd1, VEC_MIN);
		drain();

		// quarter turn of the node: exact table endpoints, pure axis swap
		program_angles(prf_pkg::angle_t'(prf_pkg::QUARTER), '0, '0);
		send_vec(CMD_TO_ECI, VEC_MAX, VEC_MIN, 32'sd12345);
		send_vec(CMD_TO_PERIFOCAL, VEC_MIN, VEC_MAX, -32'sd12345);
		drain();

		// eighth turn on all three angles: full-scale inputs must saturate
		program_angles(prf_pkg::angle_t'(prf_pkg::QUARTER / 2),
		               prf_pkg::angle_t'(prf_pkg::QUARTER / 2),
		               prf_pkg::angle_t'(prf_pkg::QUARTER / 2));
		send_vec(CMD_TO_ECI, VEC_MAX, VEC_MAX, VEC_MAX);
		send_vec(CMD_TO_PERIFOCAL, VEC_MIN, VEC_MIN, VEC_MIN);
		send_vec(CMD_TO_ECI, VEC_MAX, VEC_MIN, VEC_MAX);
		send_vec(CMD_TO_PERIFOCAL, VEC_MIN, VEC_MAX, VEC_MIN);
		// tiny inputs exercise the half-up rounding
		send_vec(CMD_TO_ECI, 32'sd1, 32'sd1, 32'sd1);
		send_vec(CMD_TO_PERIFOCAL, -32'sd1, -32'sd1, -32'sd1);
		drain();

		// out-of-range register index must leave the matrix untouched
		write_angle(REG_UNUSED, '1);
		send_vec(CMD_TO_ECI, VEC_MAX, 32'sd0, VEC_MIN);
		send_vec(CMD_TO_PERIFOCAL, 32'sd0, VEC_MAX, VEC_MIN);
		drain();

		random_phase(0);

		send_idle_pct = 85;
		recv_idle_pct = 7;
		random_phase(1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(2);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_perifocal_eci_frame_rotation OK");
		end else begin
			$display("tb_perifocal_eci_frame_rotation NOT OK");
		end
		$finish;
	end

endmodule
